/* design/spq_pkg.sv */
package spq_pkg;

	// Built storage depth and derived widths
	localparam int DEPTH = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 7;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Request word
	typedef struct packed {
		logic               operation;
		logic signed [31:0] value;
		logic [15:0]        priority_req;
	} req_word_t;

	// Response word
	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [6:0]         occupancy;
	} rsp_word_t;

	// One stored entry
	typedef struct packed {
		logic [15:0]        prio;
		logic signed [31:0] value;
	} entry_t;

	typedef enum logic [1:0] {
		RES_FULL,
		RES_EMPTY,
		RES_ENQ_OK,
		RES_DEQ_OK
	} res_kind_t;

	typedef enum logic {
		RD_COUNT_M1,
		RD_POS_M2
	} rd_sel_t;

	typedef enum logic {
		WR_SHIFT,
		WR_NEW
	} wr_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic      req_load;
		logic      pos_init;
		logic      pos_dec;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wr_sel_t   wr_sel;
		logic      cnt_dec;
		logic      res_load;
		res_kind_t res_kind;
	} ctrl_t;

	// Datapath to controller
	typedef struct packed {
		logic is_deq;
		logic room;
		logic empty;
		logic pri_gt;
		logic pos_one;
		logic out_free;
	} stat_t;

endpackage

/* design/sorted_priority_queue.sv */
// From word accept: a refused enqueue or an empty dequeue loads its result word in
// the decide state; a dequeue reads the top entry there and returns it in deq-data; an
// enqueue moves each held entry of higher priority up one slot over the RAM port and
// stops at the first that is not higher or at the bottom, then writes the new entry.
// Words are taken only in idle; a stalled result word holds the controller until it
// leaves. Reset clears the entry count, capacity goes to 64; entry RAM is not cleared.
module sorted_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  spq_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output spq_pkg::rsp_word_t rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	spq_pkg::ctrl_t ctrl;
	spq_pkg::stat_t stat;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	spq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

endmodule

/* design/spq_ram.sv */
module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/spq_datapath.sv */
module spq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::ctrl_t    ctrl,
	output spq_pkg::stat_t    stat,
	input  spq_pkg::req_word_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::rsp_word_t rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	spq_pkg::req_word_t            req_q;
	spq_pkg::rsp_word_t            rsp_q;
	logic                          rsp_valid_q;
	logic [spq_pkg::CNT_W-1:0]     count_q;
	logic [spq_pkg::ADDR_W-1:0]    pos_q;
	logic [spq_pkg::CAP_W-1:0]     capacity_q;
	logic [spq_pkg::ADDR_W-1:0]    rd_addr;
	logic [spq_pkg::ADDR_W-1:0]    count_m1;
	spq_pkg::entry_t               rd_entry;
	spq_pkg::entry_t               wr_entry;
	spq_pkg::entry_t               new_entry;

	// Config register: capacity at byte address 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= spq_pkg::CAP_W'(64);
		end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
			capacity_q <= pwdata[spq_pkg::CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? 32'(capacity_q) : 32'd0;

	// Latched request
	always_ff @(posedge clk) begin
		if (ctrl.req_load) begin
			req_q <= req;
		end
	end

	// Insert position
	always_ff @(posedge clk) begin
		if (ctrl.pos_init) begin
			pos_q <= spq_pkg::ADDR_W'(count_q);
		end else if (ctrl.pos_dec) begin
			pos_q <= pos_q - spq_pkg::ADDR_W'(1);
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.cnt_dec) begin
			count_q <= count_q - spq_pkg::CNT_W'(1);
		end else if (ctrl.res_load && ctrl.res_kind == spq_pkg::RES_ENQ_OK) begin
			count_q <= count_q + spq_pkg::CNT_W'(1);
		end
	end

	// Entry store
	assign count_m1 = spq_pkg::ADDR_W'(count_q - spq_pkg::CNT_W'(1));
	assign rd_addr = (ctrl.rd_sel == spq_pkg::RD_COUNT_M1) ? count_m1
		: pos_q - spq_pkg::ADDR_W'(2);
	assign new_entry = '{prio: req_q.priority_req, value: req_q.value};
	assign wr_entry = (ctrl.wr_sel == spq_pkg::WR_SHIFT) ? rd_entry : new_entry;

	spq_ram #(
		.WIDTH($bits(spq_pkg::entry_t)),
		.DEPTH(spq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.wr_en),
		.waddr(pos_q),
		.wdata(wr_entry),
		.re   (ctrl.rd_en),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			case (ctrl.res_kind)
				spq_pkg::RES_FULL: begin
					rsp_q <= '{result_value: '0, status: spq_pkg::STATUS_FULL,
						occupancy: 7'(count_q)};
				end
				spq_pkg::RES_EMPTY: begin
					rsp_q <= '{result_value: '0, status: spq_pkg::STATUS_EMPTY,
						occupancy: 7'(count_q)};
				end
				spq_pkg::RES_ENQ_OK: begin
					rsp_q <= '{result_value: '0, status: spq_pkg::STATUS_OK,
						occupancy: 7'(count_q + spq_pkg::CNT_W'(1))};
				end
				spq_pkg::RES_DEQ_OK: begin
					rsp_q <= '{result_value: rd_entry.value, status: spq_pkg::STATUS_OK,
						occupancy: 7'(count_q)};
				end
				default: begin
					rsp_q <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Status back to the controller
	assign stat.is_deq = (req_q.operation == spq_pkg::OP_DEQ);
	assign stat.room = (spq_pkg::CMP_W'(count_q) < spq_pkg::CMP_W'(capacity_q))
		&& (spq_pkg::CMP_W'(count_q) < spq_pkg::CMP_W'(spq_pkg::DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.pri_gt = (rd_entry.prio > req_q.priority_req);
	assign stat.pos_one = (pos_q == spq_pkg::ADDR_W'(1));
	assign stat.out_free = !rsp_valid_q || !rsp_stall;

endmodule

/* design/spq_ctrl.sv */
module spq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spq_pkg::stat_t stat,
	output spq_pkg::ctrl_t ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ENQ_CMP,
		ST_ENQ_PUT,
		ST_DEQ_DATA
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		ctrl = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctrl.req_load = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.is_deq) begin
					if (stat.empty) begin
						if (stat.out_free) begin
							ctrl.res_load = 1'b1;
							ctrl.res_kind = spq_pkg::RES_EMPTY;
							state_d = ST_IDLE;
						end
					end else begin
						// top entry sits at count-1
						ctrl.rd_en = 1'b1;
						ctrl.rd_sel = spq_pkg::RD_COUNT_M1;
						ctrl.cnt_dec = 1'b1;
						state_d = ST_DEQ_DATA;
					end
				end else if (!stat.room) begin
					if (stat.out_free) begin
						ctrl.res_load = 1'b1;
						ctrl.res_kind = spq_pkg::RES_FULL;
						state_d = ST_IDLE;
					end
				end else begin
					ctrl.pos_init = 1'b1;
					if (stat.empty) begin
						state_d = ST_ENQ_PUT;
					end else begin
						ctrl.rd_en = 1'b1;
						ctrl.rd_sel = spq_pkg::RD_COUNT_M1;
						state_d = ST_ENQ_CMP;
					end
				end
			end
			ST_ENQ_CMP: begin
				// entry at pos-1 is on the read port
				if (stat.pri_gt) begin
					ctrl.wr_en = 1'b1;
					ctrl.wr_sel = spq_pkg::WR_SHIFT;
					ctrl.pos_dec = 1'b1;
					if (stat.pos_one) begin
						state_d = ST_ENQ_PUT;
					end else begin
						ctrl.rd_en = 1'b1;
						ctrl.rd_sel = spq_pkg::RD_POS_M2;
					end
				end else begin
					state_d = ST_ENQ_PUT;
				end
			end
			ST_ENQ_PUT: begin
				if (stat.out_free) begin
					ctrl.wr_en = 1'b1;
					ctrl.wr_sel = spq_pkg::WR_NEW;
					ctrl.res_load = 1'b1;
					ctrl.res_kind = spq_pkg::RES_ENQ_OK;
					state_d = ST_IDLE;
				end
			end
			ST_DEQ_DATA: begin
				if (stat.out_free) begin
					ctrl.res_load = 1'b1;
					ctrl.res_kind = spq_pkg::RES_DEQ_OK;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and registered stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_stall <= 1'b0;
		end else begin
			state_q <= state_d;
			req_stall <= (state_d != ST_IDLE);
		end
	end

endmodule
